// ----- rtl/sraba_pkg.sv -----
`timescale 1ns / 1ps

package sraba_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int COUNT_W   = 17;
   localparam int SUM_W     = 49;
   localparam int PROG_W    = 33;
   localparam int QUOT_W    = 34;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DSH_W     = COUNT_W + DIV_STEPS - 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic REG_IN_COUNT  = 1'b0;
   localparam logic REG_OUT_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIN_START,
      ST_BIN_DIV,
      ST_BIN_OUT,
      ST_ADD,
      ST_EXP_DIV,
      ST_EXP_OUT,
      ST_PASS_OUT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] in_count;
      logic [COUNT_W-1:0] out_count;
   } count_pair_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } div_cmd_type;

endpackage

// ----- rtl/series_resample_bin_average.sv -----
`timescale 1ns / 1ps

// Resamples a series of in_count samples, one per request, into out_count results.
// When shrinking, valid samples are averaged in bins whose edges are found by exact
// integer comparison, and a bin without a valid sample gives a missing result; the
// open bin is always flushed on the last sample of the series. When expanding, each
// sample is repeated by floor-index rule, at most MAX_EXPAND times per request.
// Equal counts pass each sample through. A request is taken only when the sequencer
// is idle. Each bin average runs through one shared 34-step shift-subtract divider;
// the last request of a shrinking series may close two bins that hold a valid
// sample. An empty bin skips the divider, and a shrinking request that closes no bin
// does not use it. When expanding, the same divider finds the target index in 34
// steps, and then one copy leaves per cycle while the response slot is free. A
// waiting result can hold the sequencer in its output step until the downstream side
// takes it.
module series_resample_bin_average #(
   parameter int MAX_LEN    = 65536,
   parameter int MAX_EXPAND = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sraba_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_sample_missing,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sraba_pkg::SAMPLE_W-1:0] rsp_value,
   output logic                                 rsp_value_missing,
   output logic                                 rsp_run_last,
   output logic                                 rsp_series_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sraba_pkg::ADDR_W-1:0]         paddr,
   input  logic [sraba_pkg::DATA_W-1:0]         pwdata,
   output logic [sraba_pkg::DATA_W-1:0]         prdata,
   output logic                                 pready
);

   localparam int CW      = sraba_pkg::COUNT_W;
   localparam int SW      = sraba_pkg::SUM_W;
   localparam int PW      = sraba_pkg::PROG_W;
   localparam int QW      = sraba_pkg::QUOT_W;
   localparam int XW      = sraba_pkg::SAMPLE_W;
   localparam int CAP     = (MAX_LEN > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_LEN;
   localparam int CPY_W   = $clog2(MAX_EXPAND + 1);

   sraba_pkg::count_pair_type counts;
   sraba_pkg::div_cmd_type    div_cmd;
   logic                      div_done;
   logic [QW-1:0]             div_quotient;
   logic [CW-1:0]             div_remainder;

   sraba_pkg::state_type state_ff, state_in;

   logic [CW-1:0]    ip_ff, ip_in;
   logic [CW-1:0]    op_ff, op_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PW-1:0]    ipp_ff, ipp_in;
   logic [PW-1:0]    opp_ff, opp_in;
   logic             flush_ff, flush_in;
   logic [CPY_W-1:0] copies_ff, copies_in;
   logic [XW-1:0]    x_ff, x_in;
   logic             miss_ff, miss_in;
   logic             last_ff, last_in;
   logic             bin_neg_ff, bin_neg_in;
   logic [XW-1:0]    bin_value_ff, bin_value_in;
   logic             bin_miss_ff, bin_miss_in;
   logic [QW-1:0]    exp_div_ff, exp_div_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]    rsp_value_ff, rsp_value_in;
   logic             rsp_missing_ff, rsp_missing_in;
   logic             rsp_run_last_ff, rsp_run_last_in;
   logic             rsp_series_last_ff, rsp_series_last_in;

   logic [CW-1:0]    n_eff, s_eff;
   logic             is_last;
   logic             flush_cond;
   logic [QW-1:0]    exp_dividend;
   logic [SW-1:0]    sum_mag;
   logic [QW-1:0]    exp_diff;
   logic [CPY_W-1:0] exp_copies;
   logic [XW-1:0]    quot_low;
   logic [XW-1:0]    copy_value;
   logic             slot_free;

   sraba_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .counts  (counts)
   );

   sraba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign n_eff = (counts.in_count == '0) ? CW'(1) :
                  (counts.in_count > CW'(CAP)) ? CW'(CAP) : counts.in_count;
   assign s_eff = (counts.out_count == '0) ? CW'(1) :
                  (counts.out_count > CW'(CAP)) ? CW'(CAP) : counts.out_count;

   assign is_last      = ({1'b0, ip_ff} + (CW + 1)'(1)) >= {1'b0, n_eff};
   assign flush_cond   = ({1'b0, ipp_ff} + (PW + 1)'(s_eff)) >
                         ({1'b0, opp_ff} + (PW + 1)'(n_eff));
   assign exp_dividend = QW'(ipp_ff) + QW'(s_eff) + QW'(n_eff) - QW'(1);
   assign sum_mag      = sum_ff[SW-1] ? (~sum_ff + SW'(1)) : sum_ff;
   assign exp_diff     = div_quotient - QW'(op_ff);
   assign exp_copies   = (exp_diff > QW'(MAX_EXPAND)) ? CPY_W'(MAX_EXPAND) :
                         exp_diff[CPY_W-1:0];
   assign quot_low     = div_quotient[XW-1:0];
   assign copy_value   = miss_ff ? '0 : x_ff;
   assign slot_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in           = state_ff;
      ip_in              = ip_ff;
      op_in              = op_ff;
      sum_in             = sum_ff;
      cnt_in             = cnt_ff;
      ipp_in             = ipp_ff;
      opp_in             = opp_ff;
      flush_in           = flush_ff;
      copies_in          = copies_ff;
      x_in               = x_ff;
      miss_in            = miss_ff;
      last_in            = last_ff;
      bin_neg_in         = bin_neg_ff;
      bin_value_in       = bin_value_ff;
      bin_miss_in        = bin_miss_ff;
      exp_div_in         = exp_div_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_missing_in     = rsp_missing_ff;
      rsp_run_last_in    = rsp_run_last_ff;
      rsp_series_last_in = rsp_series_last_ff;
      div_cmd.start      = 1'b0;
      div_cmd.dividend   = SW'(exp_dividend);
      div_cmd.divisor    = n_eff;
      req_ready          = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sraba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x_in     = req_sample;
               miss_in  = req_sample_missing;
               last_in  = is_last;
               flush_in = 1'b0;
               if (s_eff < n_eff) begin
                  if (flush_cond) begin
                     flush_in = 1'b1;
                     state_in = sraba_pkg::ST_BIN_START;
                  end else begin
                     state_in = sraba_pkg::ST_ADD;
                  end
               end else if (s_eff > n_eff) begin
                  div_cmd.start = 1'b1;
                  exp_div_in    = exp_dividend;
                  state_in      = sraba_pkg::ST_EXP_DIV;
               end else begin
                  state_in = sraba_pkg::ST_PASS_OUT;
               end
            end
         end
         sraba_pkg::ST_BIN_START: begin
            if (cnt_ff == '0) begin
               bin_value_in = '0;
               bin_miss_in  = 1'b1;
               state_in     = sraba_pkg::ST_BIN_OUT;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = sum_mag;
               div_cmd.divisor  = cnt_ff;
               bin_neg_in       = sum_ff[SW-1];
               state_in         = sraba_pkg::ST_BIN_DIV;
            end
         end
         sraba_pkg::ST_BIN_DIV: begin
            if (div_done) begin
               bin_value_in = bin_neg_ff ? (~quot_low + XW'(1)) : quot_low;
               bin_miss_in  = 1'b0;
               state_in     = sraba_pkg::ST_BIN_OUT;
            end
         end
         sraba_pkg::ST_BIN_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = bin_value_ff;
               rsp_missing_in = bin_miss_ff;
               sum_in         = '0;
               cnt_in         = '0;
               if (flush_ff) begin
                  rsp_run_last_in    = !last_ff;
                  rsp_series_last_in = 1'b0;
                  flush_in           = 1'b0;
                  op_in              = op_ff + CW'(1);
                  opp_in             = opp_ff + PW'(n_eff);
                  state_in           = sraba_pkg::ST_ADD;
               end else begin
                  rsp_run_last_in    = 1'b1;
                  rsp_series_last_in = 1'b1;
                  state_in           = sraba_pkg::ST_FINISH;
               end
            end
         end
         sraba_pkg::ST_ADD: begin
            if (!miss_ff) begin
               sum_in = sum_ff + {{(SW - XW){x_ff[XW-1]}}, x_ff};
               cnt_in = cnt_ff + CW'(1);
            end
            state_in = last_ff ? sraba_pkg::ST_BIN_START : sraba_pkg::ST_FINISH;
         end
         sraba_pkg::ST_EXP_DIV: begin
            if (div_done) begin
               op_in  = div_quotient[CW-1:0];
               opp_in = PW'(exp_div_ff - QW'(div_remainder));
               if (div_quotient > QW'(op_ff) && exp_copies != '0) begin
                  copies_in = exp_copies;
                  state_in  = sraba_pkg::ST_EXP_OUT;
               end else begin
                  state_in = sraba_pkg::ST_FINISH;
               end
            end
         end
         sraba_pkg::ST_EXP_OUT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_value_in       = copy_value;
               rsp_missing_in     = miss_ff;
               rsp_run_last_in    = (copies_ff == CPY_W'(1));
               rsp_series_last_in = last_ff && (copies_ff == CPY_W'(1));
               copies_in          = copies_ff - CPY_W'(1);
               if (copies_ff == CPY_W'(1)) begin
                  state_in = sraba_pkg::ST_FINISH;
               end
            end
         end
         sraba_pkg::ST_PASS_OUT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_value_in       = copy_value;
               rsp_missing_in     = miss_ff;
               rsp_run_last_in    = 1'b1;
               rsp_series_last_in = last_ff;
               op_in              = op_ff + CW'(1);
               opp_in             = opp_ff + PW'(n_eff);
               state_in           = sraba_pkg::ST_FINISH;
            end
         end
         sraba_pkg::ST_FINISH: begin
            ip_in  = ip_ff + CW'(1);
            ipp_in = ipp_ff + PW'(s_eff);
            if (last_ff) begin
               ip_in  = '0;
               op_in  = '0;
               sum_in = '0;
               cnt_in = '0;
               ipp_in = '0;
               opp_in = '0;
            end
            state_in = sraba_pkg::ST_IDLE;
         end
         default: begin
            state_in = sraba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sraba_pkg::ST_IDLE;
         ip_ff        <= '0;
         op_ff        <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         ipp_ff       <= '0;
         opp_ff       <= '0;
         flush_ff     <= 1'b0;
         copies_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ip_ff        <= ip_in;
         op_ff        <= op_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         ipp_ff       <= ipp_in;
         opp_ff       <= opp_in;
         flush_ff     <= flush_in;
         copies_ff    <= copies_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff               <= x_in;
      miss_ff            <= miss_in;
      last_ff            <= last_in;
      bin_neg_ff         <= bin_neg_in;
      bin_value_ff       <= bin_value_in;
      bin_miss_ff        <= bin_miss_in;
      exp_div_ff         <= exp_div_in;
      rsp_value_ff       <= rsp_value_in;
      rsp_missing_ff     <= rsp_missing_in;
      rsp_run_last_ff    <= rsp_run_last_in;
      rsp_series_last_ff <= rsp_series_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_value_missing = rsp_missing_ff;
   assign rsp_run_last      = rsp_run_last_ff;
   assign rsp_series_last   = rsp_series_last_ff;

endmodule

// ----- rtl/sraba_csr.sv -----
`timescale 1ns / 1ps

module sraba_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sraba_pkg::ADDR_W-1:0]       paddr,
   input  logic [sraba_pkg::DATA_W-1:0]       pwdata,
   output logic [sraba_pkg::DATA_W-1:0]       prdata,
   output logic                               pready,
   output sraba_pkg::count_pair_type          counts
);

   logic [sraba_pkg::COUNT_W-1:0] in_count_ff, in_count_in;
   logic [sraba_pkg::COUNT_W-1:0] out_count_ff, out_count_in;
   logic                          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (wr_en) begin
         case (paddr[2])
            sraba_pkg::REG_IN_COUNT:  in_count_in  = pwdata[sraba_pkg::COUNT_W-1:0];
            sraba_pkg::REG_OUT_COUNT: out_count_in = pwdata[sraba_pkg::COUNT_W-1:0];
            default: begin
               in_count_in  = in_count_ff;
               out_count_in = out_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         sraba_pkg::REG_IN_COUNT:
            prdata = {{(sraba_pkg::DATA_W-sraba_pkg::COUNT_W){1'b0}}, in_count_ff};
         sraba_pkg::REG_OUT_COUNT:
            prdata = {{(sraba_pkg::DATA_W-sraba_pkg::COUNT_W){1'b0}}, out_count_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= sraba_pkg::COUNT_W'(1);
         out_count_ff <= sraba_pkg::COUNT_W'(1);
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
      end
   end

   assign counts.in_count  = in_count_ff;
   assign counts.out_count = out_count_ff;

endmodule

// ----- rtl/sraba_div.sv -----
`timescale 1ns / 1ps

module sraba_div (
   input  logic                              clock,
   input  logic                              reset,
   input  sraba_pkg::div_cmd_type            cmd,
   output logic                              done,
   output logic [sraba_pkg::QUOT_W-1:0]      quotient,
   output logic [sraba_pkg::COUNT_W-1:0]     remainder
);

   logic [sraba_pkg::SUM_W-1:0]  rem_ff, rem_in;
   logic [sraba_pkg::DSH_W-1:0]  dsh_ff, dsh_in;
   logic [sraba_pkg::QUOT_W-1:0] quo_ff, quo_in;
   logic [sraba_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         fits;

   assign fits = {{(sraba_pkg::DSH_W-sraba_pkg::SUM_W){1'b0}}, rem_ff} >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.dividend;
         dsh_in  = {cmd.divisor, {(sraba_pkg::DIV_STEPS-1){1'b0}}};
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff[sraba_pkg::SUM_W-1:0];
         end
         quo_in  = {quo_ff[sraba_pkg::QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + sraba_pkg::STEP_W'(1);
         if (step_ff == sraba_pkg::STEP_W'(sraba_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[sraba_pkg::COUNT_W-1:0];

endmodule
